### hw/rtl/bira_pkg.sv
// Package for the beat interval rate averager.
// Holds register indexes, reset values, ring sizing and the sequencer state type.
// Depends on nothing; imported by beat_interval_rate_averager.
package bira_pkg;

    localparam int RING_DEPTH = 10;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W      = $clog2(RING_DEPTH * 255 + 1);

    // The ring average is taken as a multiply by a rounded-up reciprocal.
    localparam int AVG_SHIFT  = 24;
    localparam int RECIP_W    = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << AVG_SHIFT) + RING_DEPTH - 1) / RING_DEPTH);

    localparam int DVD_W      = 20;
    localparam int REM_W      = 16;
    localparam int CNT_W      = 5;

    localparam logic [15:0] BEAT_MS_PER_MIN = 16'd60000;
    localparam logic [4:0]  RATE_STEPS      = 5'd16;
    localparam logic [4:0]  FILT_STEPS      = 5'd20;
    localparam logic [4:0]  FILT_DIVISOR    = 5'd10;

    localparam logic [2:0] REG_PRESENCE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ACCEPT_LOW         = 3'd1;
    localparam logic [2:0] REG_ACCEPT_HIGH        = 3'd2;
    localparam logic [2:0] REG_CLAMP_LOW          = 3'd3;
    localparam logic [2:0] REG_CLAMP_HIGH         = 3'd4;

    localparam logic [17:0] RST_PRESENCE_THRESHOLD = 18'd50000;
    localparam logic [7:0]  RST_ACCEPT_LOW         = 8'd45;
    localparam logic [7:0]  RST_ACCEPT_HIGH        = 8'd130;
    localparam logic [7:0]  RST_CLAMP_LOW          = 8'd50;
    localparam logic [7:0]  RST_CLAMP_HIGH         = 8'd130;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_RING,
        S_AVG,
        S_FILT,
        S_DONE
    } state_t;

endpackage

### hw/rtl/beat_interval_rate_averager.sv
// Beat interval rate averager: beat intervals to a smoothed, clamped rate in bpm.
// Uses one bit-serial restoring divider for both the rate and the filter update.
// Depends on bira_pkg.
//
//   channel | direction | signals
//   --------+-----------+-------------------------------------------------
//   cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//   in      | in        | in_valid, in_ready, beat_seen, ir_level, now_ms
//   out     | out       | out_valid, out_ready, rate_bpm
//
// A sample without a counted beat, or with a non-positive interval, goes from S_IDLE straight to S_DONE.
// A full beat runs 16 divider steps for 60000/interval and 20 for
// the filter division by ten, each step one quotient bit of the shared divider.
// Reset clears the ring, the filter, the last beat time and the registers to defaults.
// A waiting result in the output register does not hold back acceptance of the next beat,
// but that beat waits in S_DONE with in_ready low until it is free; cfg_ready is always high.
module beat_interval_rate_averager
    import bira_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        beat_seen,
    input  logic [17:0] ir_level,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  rate_bpm
);

    state_t state_reg, state_next;

    logic [17:0] thr_reg, thr_next;
    logic [7:0]  acc_lo_reg, acc_lo_next;
    logic [7:0]  acc_hi_reg, acc_hi_next;
    logic [7:0]  clo_reg, clo_next;
    logic [7:0]  chi_reg, chi_next;

    logic [31:0]       last_reg, last_next;
    logic [7:0]        ring_reg [RING_DEPTH];
    logic [7:0]        ring_next [RING_DEPTH];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [15:0]       filt_reg, filt_next;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [30:0]      dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             zero_reg, zero_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    logic [31:0]                interval;
    logic [REM_W:0]             trial;
    logic                       fits;
    logic [DVD_W-1:0]           step_dvd;
    logic [REM_W-1:0]           step_rem;
    logic [15:0]                quot;
    logic                       low_ok;
    logic                       high_ok;
    logic [SUM_W+RECIP_W-1:0]   avg_prod;
    logic [7:0]                 avg;
    logic [DVD_W-1:0]           filt_in;
    logic [7:0]                 filt_int;
    logic [7:0]                 report;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rate_bpm  = out_data_reg;

    assign interval = now_ms - last_reg;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = (dsr_reg[30:REM_W+1] == '0) && (trial >= dsr_reg[REM_W:0]);
    assign step_rem = fits ? REM_W'(trial - dsr_reg[REM_W:0]) : REM_W'(trial);
    assign step_dvd = {dvd_reg[DVD_W-2:0], fits};

    assign quot    = dvd_reg[15:0];
    assign low_ok  = ({8'd0, acc_lo_reg} < quot)
                  || (({8'd0, acc_lo_reg} == quot) && (rem_reg != '0));
    assign high_ok = {8'd0, acc_hi_reg} > quot;

    assign avg_prod = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(AVG_RECIP);
    assign avg      = avg_prod[AVG_SHIFT +: 8];
    assign filt_in  = DVD_W'({filt_reg, 3'b000}) + DVD_W'(filt_reg) + DVD_W'({avg, 8'd0});

    assign filt_int = filt_reg[15:8];

    always_comb
    begin
        if (filt_reg == '0)
        begin
            report = 8'd0;
        end
        else if (filt_int < clo_reg)
        begin
            report = clo_reg;
        end
        else if (filt_int > chi_reg)
        begin
            report = chi_reg;
        end
        else
        begin
            report = filt_int;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        acc_lo_next    = acc_lo_reg;
        acc_hi_next    = acc_hi_reg;
        clo_next       = clo_reg;
        chi_next       = chi_reg;
        last_next      = last_reg;
        ring_next      = ring_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        filt_next      = filt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        cnt_next       = cnt_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRESENCE_THRESHOLD: thr_next    = cfg_data;
                REG_ACCEPT_LOW:         acc_lo_next = cfg_data[7:0];
                REG_ACCEPT_HIGH:        acc_hi_next = cfg_data[7:0];
                REG_CLAMP_LOW:          clo_next    = cfg_data[7:0];
                REG_CLAMP_HIGH:         chi_next    = cfg_data[7:0];
                default:                ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    zero_next  = 1'b1;
                    state_next = S_DONE;
                    if (beat_seen && (ir_level >= thr_reg))
                    begin
                        last_next = now_ms;
                        if ((interval != '0) && !interval[31])
                        begin
                            zero_next  = 1'b0;
                            dvd_next   = {BEAT_MS_PER_MIN, (DVD_W-16)'(0)};
                            rem_next   = '0;
                            dsr_next   = interval[30:0];
                            cnt_next   = RATE_STEPS - 5'd1;
                            state_next = S_RATE;
                        end
                    end
                end
            end
            S_RATE:
            begin
                dvd_next = step_dvd;
                rem_next = step_rem;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                if (low_ok && high_ok)
                begin
                    ring_next[slot_reg] = quot[7:0];
                    sum_next = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(quot[7:0]);
                    if (slot_reg == SLOT_W'(RING_DEPTH - 1))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                    state_next = S_AVG;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_AVG:
            begin
                dvd_next   = filt_in;
                rem_next   = '0;
                dsr_next   = 31'(FILT_DIVISOR);
                cnt_next   = FILT_STEPS - 5'd1;
                state_next = S_FILT;
            end
            S_FILT:
            begin
                dvd_next = step_dvd;
                rem_next = step_rem;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    filt_next  = step_dvd[15:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = zero_reg ? 8'd0 : report;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= RST_PRESENCE_THRESHOLD;
            acc_lo_reg    <= RST_ACCEPT_LOW;
            acc_hi_reg    <= RST_ACCEPT_HIGH;
            clo_reg       <= RST_CLAMP_LOW;
            chi_reg       <= RST_CLAMP_HIGH;
            last_reg      <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg      <= '0;
            sum_reg       <= '0;
            filt_reg      <= '0;
            cnt_reg       <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            acc_lo_reg    <= acc_lo_next;
            acc_hi_reg    <= acc_hi_next;
            clo_reg       <= clo_next;
            chi_reg       <= chi_next;
            last_reg      <= last_next;
            ring_reg      <= ring_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            filt_reg      <= filt_next;
            cnt_reg       <= cnt_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        out_data_reg <= out_data_next;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for beat_interval_rate_averager: directed and random samples
// under random idling on both channels, with a scoreboard that predicts every rate.
// Depends on bira_pkg and the beat_interval_rate_averager RTL.
module testbench;
    import bira_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [17:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        beat_seen;
    logic [17:0] ir_level;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  rate_bpm;

    beat_interval_rate_averager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .beat_seen (beat_seen),
        .ir_level  (ir_level),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rate_bpm  (rate_bpm)
    );

    class rate_scoreboard;
        logic [17:0] presence_thr;
        logic [7:0]  accept_lo;
        logic [7:0]  accept_hi;
        logic [7:0]  clamp_lo;
        logic [7:0]  clamp_hi;
        logic [31:0] last_beat_ms;
        logic [7:0]  rate_hist [RING_DEPTH];
        int unsigned hist_slot;
        logic [15:0] filt_q88;
        logic [7:0]  pending_rates [$];
        int          errors;

        function new();
            presence_thr = RST_PRESENCE_THRESHOLD;
            accept_lo    = RST_ACCEPT_LOW;
            accept_hi    = RST_ACCEPT_HIGH;
            clamp_lo     = RST_CLAMP_LOW;
            clamp_hi     = RST_CLAMP_HIGH;
            last_beat_ms = '0;
            foreach (rate_hist[k])
                rate_hist[k] = '0;
            hist_slot = 0;
            filt_q88  = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [17:0] data);
            case (idx)
                REG_PRESENCE_THRESHOLD: presence_thr = data;
                REG_ACCEPT_LOW:         accept_lo    = data[7:0];
                REG_ACCEPT_HIGH:        accept_hi    = data[7:0];
                REG_CLAMP_LOW:          clamp_lo     = data[7:0];
                REG_CLAMP_HIGH:         clamp_hi     = data[7:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic beat, logic [17:0] ir, logic [31:0] stamp);
            logic [31:0] span;
            logic [31:0] next_filt;
            int unsigned total;
            int unsigned mean;
            logic [7:0]  rate;
            rate = '0;
            if (beat && ir >= presence_thr)
            begin
                span = stamp - last_beat_ms;
                last_beat_ms = stamp;
                if (span != 0 && !span[31])
                begin
                    if (64'(accept_lo) * 64'(span) < 64'd60000 &&
                        64'(accept_hi) * 64'(span) > 64'd60000)
                    begin
                        rate_hist[hist_slot] = 8'(32'd60000 / span);
                        hist_slot = (hist_slot + 1) % RING_DEPTH;
                        total = 0;
                        foreach (rate_hist[k])
                            total += rate_hist[k];
                        mean = total / RING_DEPTH;
                        next_filt = (32'd9 * filt_q88 + 32'd256 * mean) / 32'd10;
                        filt_q88 = next_filt[15:0];
                    end
                    if (filt_q88 != 0)
                    begin
                        rate = filt_q88[15:8];
                        if (rate < clamp_lo)
                            rate = clamp_lo;
                        else if (rate > clamp_hi)
                            rate = clamp_hi;
                    end
                end
            end
            pending_rates.push_back(rate);
        endfunction

        function void check_rate(logic [7:0] actual);
            logic [7:0] wanted;
            if (pending_rates.size() == 0)
            begin
                $display("%0t: rate_bpm %0d arrived with no sample outstanding",
                         $time, actual);
                errors++;
            end
            else
            begin
                wanted = pending_rates.pop_front();
                if (actual !== wanted)
                begin
                    $display("%0t: rate_bpm expected %0d, actual %0d", $time, wanted, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_rates.size();
        endfunction
    endclass

    rate_scoreboard sb;
    logic [31:0]    clock_ms;
    bit             in_quiet;
    bit             out_quiet;
    int             stall_left;
    int             cycle_count;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // One rate is taken from the output on a rising edge where out_valid and out_ready are both high.
    initial
    begin
        stall_left = 0;
        out_quiet  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_rate(rate_bpm);
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (!out_quiet)
                    stall_left = pick_gap();
            end
            if ($urandom_range(0, 199) == 0)
                out_quiet = !out_quiet;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic beat, input logic [17:0] ir,
                               input logic [31:0] stamp);
        int gap;
        gap = in_quiet ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        beat_seen = beat;
        ir_level  = ir;
        now_ms    = stamp;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_sample(beat, ir, stamp);
        if ($urandom_range(0, 99) == 0)
            in_quiet = !in_quiet;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic run_directed();
        int n;
        send_sample(1'b0, 18'h3FFFF, 32'hFFFF_FFFF);
        send_sample(1'b1, 18'd49999, 32'd1000);
        send_sample(1'b1, 18'd50000, 32'd0);
        send_sample(1'b1, 18'd50000, 32'd200);
        send_sample(1'b1, 18'h3FFFF, 32'd1000);
        send_sample(1'b1, 18'd70000, 32'd1800);
        send_sample(1'b1, 18'd70000, 32'd2262);
        send_sample(1'b1, 18'd70000, 32'd2723);
        send_sample(1'b1, 18'd70000, 32'd4056);
        send_sample(1'b1, 18'd70000, 32'd5390);
        send_sample(1'b1, 18'd70000, 32'h8000_150E);
        send_sample(1'b1, 18'd70000, 32'h8000_182E);
        send_sample(1'b1, 18'd60000, 32'd0);
        send_sample(1'b1, 18'd60000, 32'hFFFF_FFFF);
        send_sample(1'b1, 18'd60000, 32'h0000_02FF);
        send_sample(1'b0, 18'd0, 32'd0);
        clock_ms = 32'h0000_02FF;
        for (n = 0; n < 12; n++)
        begin
            clock_ms += $urandom_range(470, 1300);
            send_sample(1'b1, 18'($urandom_range(50000, 262143)), clock_ms);
        end
    endtask

    task automatic run_random(input int count);
        int          counted;
        int          r;
        logic        beat;
        logic [17:0] ir;
        counted = 0;
        while (counted < count)
        begin
            r    = $urandom_range(0, 99);
            beat = 1'b1;
            ir   = (sb.presence_thr == 0) ? 18'($urandom)
                                          : 18'($urandom_range(262143, sb.presence_thr));
            if (r < 65)
                clock_ms += 60000 / $urandom_range(20, 255) + $urandom_range(0, 3);
            else if (r < 72)
                clock_ms += $urandom_range(1, 300);
            else if (r < 78)
                clock_ms += $urandom_range(1500, 200000);
            else if (r < 84)
                clock_ms = $urandom;
            else if (r < 92)
            begin
                beat = 1'b0;
                ir   = 18'($urandom);
                clock_ms += $urandom_range(0, 20);
            end
            else
            begin
                if (sb.presence_thr == 0)
                    beat = 1'b0;
                else
                    ir = 18'($urandom_range(sb.presence_thr - 1, 0));
                clock_ms += $urandom_range(0, 1500);
            end
            send_sample(beat, ir, clock_ms);
            counted++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cycle_count = 0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        beat_seen   = 1'b0;
        ir_level    = '0;
        now_ms      = '0;
        out_ready   = 1'b0;
        in_quiet    = 1'b0;
        clock_ms    = '0;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random(270);
        drain();

        write_reg(REG_PRESENCE_THRESHOLD, 18'd0);
        write_reg(REG_ACCEPT_LOW, 18'd0);
        write_reg(REG_ACCEPT_HIGH, 18'd255);
        write_reg(REG_CLAMP_LOW, 18'd0);
        write_reg(REG_CLAMP_HIGH, 18'd255);
        run_random(300);
        drain();

        write_reg(REG_PRESENCE_THRESHOLD, 18'h3FFFF);
        write_reg(REG_ACCEPT_LOW, 18'd60);
        write_reg(REG_ACCEPT_HIGH, 18'd110);
        write_reg(REG_CLAMP_LOW, 18'd200);
        write_reg(REG_CLAMP_HIGH, 18'd10);
        run_random(250);
        drain();

        write_reg(REG_PRESENCE_THRESHOLD, 18'($urandom_range(0, 262143)));
        write_reg(REG_ACCEPT_LOW, 18'($urandom_range(30, 90)));
        write_reg(REG_ACCEPT_HIGH, 18'($urandom_range(100, 255)));
        write_reg(REG_CLAMP_LOW, 18'($urandom_range(0, 255)));
        write_reg(REG_CLAMP_HIGH, 18'($urandom_range(0, 255)));
        run_random(250);
        drain();

        write_reg(REG_PRESENCE_THRESHOLD, 18'd255);
        write_reg(REG_ACCEPT_LOW, 18'd255);
        write_reg(REG_ACCEPT_HIGH, 18'd255);
        write_reg(REG_CLAMP_LOW, 18'd90);
        write_reg(REG_CLAMP_HIGH, 18'd40);
        run_random(150);
        drain();

        write_reg(REG_PRESENCE_THRESHOLD, 18'd50000);
        write_reg(REG_ACCEPT_LOW, 18'd45);
        write_reg(REG_ACCEPT_HIGH, 18'd130);
        write_reg(REG_CLAMP_LOW, 18'd50);
        write_reg(REG_CLAMP_HIGH, 18'd130);
        run_random(150);
        drain();

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
